FILE: hdl/gng_pkg.sv
// ---------------------------------------------------------------------------
// gng_pkg
// Shared constants and types for the grid neighbour generator.
// ---------------------------------------------------------------------------
package gng_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(CELL_COUNT);

  // usable grid size is bounded by the coordinate range and by the store
  localparam int COORD_SPAN = 1 << COORD_W;
  localparam int WIDTH_CAP  = (MAX_WIDTH  < COORD_SPAN) ? MAX_WIDTH  : COORD_SPAN;
  localparam int HEIGHT_CAP = (MAX_HEIGHT < COORD_SPAN) ? MAX_HEIGHT : COORD_SPAN;

  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } gng_dims_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
  } gng_mem_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] v;
    v = (r == '0) ? DIM_W'(1) : r;
    if (v > cap) v = cap;
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x));
  endfunction

endpackage

FILE: hdl/gng_ram.sv
// ---------------------------------------------------------------------------
// gng_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module gng_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/gng_seq.sv
// ---------------------------------------------------------------------------
// gng_seq
// Item sequencer: stores cell writes, scans the eight neighbours of a query
// through the bitmap read port and emits the open ones one word at a time.
// ---------------------------------------------------------------------------
module gng_seq
  import gng_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  gng_dims_t           dims,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [COORD_W-1:0]  cell_x,
  input  logic [COORD_W-1:0]  cell_y,
  input  logic                passable,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  neighbour_x,
  output logic [COORD_W-1:0]  neighbour_y,
  output logic                found,
  output logic                last,
  output gng_mem_req_t        mem_req,
  input  logic                mem_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LAST, S_EMIT} state_t;

  typedef enum logic [2:0] {
    D_RIGHT, D_LEFT, D_UP, D_DOWN, D_UP_LEFT, D_UP_RIGHT, D_DOWN_LEFT, D_DOWN_RIGHT
  } dir_t;

  state_t             state;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [2:0]         rd_idx;
  logic [2:0]         pend_idx;
  logic               rd_pend;
  logic [7:0]         open_bits;
  logic [7:0]         hits;

  logic               accept;
  logic               in_grid;
  logic               in_store;
  logic [7:0]         open_now;
  logic [7:0]         hits_next;
  logic               rng_r, rng_l, rng_u, rng_d;
  logic               o_r, o_l, o_u, o_d;
  logic [7:0]         sel;
  logic [2:0]         sel_idx;
  logic [COORD_W-1:0] rd_x, rd_y, em_x, em_y;
  logic               slot_free;

  function automatic logic [2*COORD_W-1:0] nbr(input logic [2:0] k,
                                               input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
    logic [COORD_W-1:0] xp, xm, yp, ym;
    logic [2*COORD_W-1:0] r;
    xp = x + COORD_W'(1);
    xm = x - COORD_W'(1);
    yp = y + COORD_W'(1);
    ym = y - COORD_W'(1);
    unique case (dir_t'(k))
      D_RIGHT:      r = {xp, y};
      D_LEFT:       r = {xm, y};
      D_UP:         r = {x, ym};
      D_DOWN:       r = {x, yp};
      D_UP_LEFT:    r = {xm, ym};
      D_UP_RIGHT:   r = {xp, ym};
      D_DOWN_LEFT:  r = {xm, yp};
      D_DOWN_RIGHT: r = {xp, yp};
      default:      r = {x, y};
    endcase
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_grid   = ({1'b0, cell_x} < dims.w) && ({1'b0, cell_y} < dims.h);
  assign in_store  = (32'(cell_x) < MAX_WIDTH) && (32'(cell_y) < MAX_HEIGHT);
  assign slot_free = !out_valid || out_ready;

  assign {rd_x, rd_y} = nbr(rd_idx, qx, qy);
  assign {em_x, em_y} = nbr(sel_idx, qx, qy);

  always_comb begin
    mem_req.we    = accept && !action && in_store;
    mem_req.waddr = cell_addr(cell_x, cell_y);
    mem_req.wdata = passable;
    mem_req.raddr = cell_addr(rd_x, rd_y);
  end

  // neighbour qualification once all eight cells are in
  always_comb begin
    open_now    = open_bits;
    open_now[7] = mem_rdata;
    rng_r = ({1'b0, qx} + DIM_W'(1)) < dims.w;
    rng_l = (qx != '0);
    rng_u = (qy != '0);
    rng_d = ({1'b0, qy} + DIM_W'(1)) < dims.h;
    o_r = rng_r && open_now[D_RIGHT];
    o_l = rng_l && open_now[D_LEFT];
    o_u = rng_u && open_now[D_UP];
    o_d = rng_d && open_now[D_DOWN];
    hits_next[D_RIGHT]      = o_r;
    hits_next[D_LEFT]       = o_l;
    hits_next[D_UP]         = o_u;
    hits_next[D_DOWN]       = o_d;
    hits_next[D_UP_LEFT]    = o_u && o_l && open_now[D_UP_LEFT];
    hits_next[D_UP_RIGHT]   = o_u && o_r && open_now[D_UP_RIGHT];
    hits_next[D_DOWN_LEFT]  = o_d && o_l && open_now[D_DOWN_LEFT];
    hits_next[D_DOWN_RIGHT] = o_d && o_r && open_now[D_DOWN_RIGHT];
  end

  always_comb begin
    sel     = hits & (~hits + 8'd1);
    sel_idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (sel[i]) sel_idx = 3'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_pend) begin
        open_bits[pend_idx] <= mem_rdata;
      end
      rd_pend <= (state == S_READ);
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && action) begin
            qx     <= cell_x;
            qy     <= cell_y;
            rd_idx <= '0;
            hits   <= '0;
            state  <= in_grid ? S_READ : S_EMIT;
          end
        end
        S_READ: begin
          pend_idx <= rd_idx;
          rd_idx   <= rd_idx + 3'd1;
          if (rd_idx == 3'(D_DOWN_RIGHT)) state <= S_LAST;
        end
        S_LAST: begin
          hits  <= hits_next;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            if (hits == '0) begin
              neighbour_x <= '0;
              neighbour_y <= '0;
              found       <= 1'b0;
              last        <= 1'b1;
              state       <= S_IDLE;
            end else begin
              neighbour_x <= em_x;
              neighbour_y <= em_y;
              found       <= 1'b1;
              last        <= ((hits & ~sel) == '0);
              hits        <= hits & ~sel;
              if ((hits & ~sel) == '0) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> state == S_IDLE)
    else $error("bitmap write outside idle");

  a_read_window: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_READ || state == S_LAST))
    else $error("read data arrives outside the scan");

  a_found_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> ({1'b0, neighbour_x} < dims.w) && ({1'b0, neighbour_y} < dims.h))
    else $error("neighbour outside grid");

  a_not_found_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last && neighbour_x == '0 && neighbour_y == '0)
    else $error("not-found word malformed");

endmodule

FILE: hdl/grid_neighbour_generator_unit.sv
// ---------------------------------------------------------------------------
// grid_neighbour_generator_unit
// Eight-connected grid neighbour lister over a stored traversability bitmap.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): action 0 writes passable into cell
// (cell_x, cell_y) and yields no word; action 1 queries that cell.
// A query yields one output word per open neighbour in the order right,
// left, up, down, up-left, up-right, down-left, down-right, with last set on
// the final word; diagonals need both adjacent orthogonal cells open. A query
// outside the grid or with no open neighbour yields a single word with
// found 0 and last 1.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 grid_width,
// index 1 grid_height; the user must write them only while the unit is
// idle, which the unit does not enforce. A write is done in the cycle it
// is accepted. A query scans its eight neighbours through the single
// bitmap read port, one cell per cycle (no scan outside the grid), and holds
// the unit until its last word is registered, waiting on a low out_ready.
// Reset clears control state and sets both grid sizes to 64; the bitmap is
// not cleared, cells must be written before they are queried. A stalled
// receiver holds the current word; a new item is still taken while the
// last word of the previous query waits.
// ---------------------------------------------------------------------------
module grid_neighbour_generator_unit
  import gng_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  input  logic [COORD_W-1:0]     cell_x,
  input  logic [COORD_W-1:0]     cell_y,
  input  logic                   passable,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_W-1:0]     neighbour_x,
  output logic [COORD_W-1:0]     neighbour_y,
  output logic                   found,
  output logic                   last
);

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  gng_dims_t        dims;
  gng_mem_req_t     mem_req;
  logic             mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(64);
      grid_height <= DIM_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.w = clamp_dim(grid_width, DIM_W'(WIDTH_CAP));
    dims.h = clamp_dim(grid_height, DIM_W'(HEIGHT_CAP));
  end

  gng_ram #(
    .WIDTH (1),
    .DEPTH (CELL_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  gng_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .dims        (dims),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .passable    (passable),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .neighbour_x (neighbour_x),
    .neighbour_y (neighbour_y),
    .found       (found),
    .last        (last),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

endmodule

FILE: tb/grid_neighbour_generator_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// grid_neighbour_generator_unit_tb
// Self-checking bench for the grid neighbour generator. A directed table
// covers corner cases, grid size clamping and diagonal blocking; random
// write/query traffic follows over several grid sizes. Each query is
// predicted from a local copy of the bitmap, or taken from the table where
// it gives the word, and each output word is checked in order. Both sides
// idle in random bursts, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module grid_neighbour_generator_unit_tb;
  import gng_pkg::*;

  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_QUERY     = 1'b1;
  localparam int   CYCLE_LIMIT   = 500000;
  localparam int   SETTLE_CYCLES = 20;
  localparam int   PHASES        = 7;
  localparam int   PHASE_ITEMS   = 25;
  localparam int   LONG_HOLD     = 300;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               found;
    logic               last;
  } nbr_word_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [DIM_W-1:0] a;
    logic [DIM_W-1:0] b;
    logic             pass;
    logic             typed;
    nbr_word_t        want;
  } dir_row_t;

  localparam nbr_word_t NONE_WORD = '{6'd0, 6'd0, 1'b0, 1'b0};
  localparam nbr_word_t NOT_FOUND = '{6'd0, 6'd0, 1'b0, 1'b1};
  localparam nbr_word_t AT_0_1    = '{6'd0, 6'd1, 1'b1, 1'b1};

  localparam logic [DIM_W-1:0] IDX_W = DIM_W'(CFG_GRID_WIDTH);
  localparam logic [DIM_W-1:0] IDX_H = DIM_W'(CFG_GRID_HEIGHT);

  localparam dir_row_t DIR_ROWS [25] = '{
    '{ROW_WRITE, 7'd0, 7'd0, 1'b0, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd1, 7'd0, 1'b1, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd0, 7'd1, 1'b1, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd1, 7'd1, 1'b0, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd2, 7'd0, 1'b1, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd2, 7'd1, 1'b1, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd0, 7'd2, 1'b1, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd1, 7'd2, 1'b1, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd2, 7'd2, 1'b1, 1'b0, NONE_WORD},
    // own cell closed, up-left closed: seven words
    '{ROW_QUERY, 7'd1, 7'd1, 1'b0, 1'b0, NONE_WORD},
    '{ROW_WRITE, 7'd0, 7'd0, 1'b1, 1'b0, NONE_WORD},
    '{ROW_QUERY, 7'd1, 7'd1, 1'b0, 1'b0, NONE_WORD},
    // up closed: both upper diagonals blocked
    '{ROW_WRITE, 7'd1, 7'd0, 1'b0, 1'b0, NONE_WORD},
    '{ROW_QUERY, 7'd1, 7'd1, 1'b0, 1'b0, NONE_WORD},
    '{ROW_QUERY, 7'd0, 7'd0, 1'b0, 1'b1, AT_0_1},
    '{ROW_CFG,   IDX_W, 7'd1, 1'b0, 1'b0, NONE_WORD},
    '{ROW_CFG,   IDX_H, 7'd1, 1'b0, 1'b0, NONE_WORD},
    '{ROW_QUERY, 7'd0, 7'd0, 1'b0, 1'b1, NOT_FOUND},
    '{ROW_QUERY, 7'd1, 7'd1, 1'b0, 1'b1, NOT_FOUND},
    '{ROW_CFG,   IDX_W, 7'd0, 1'b0, 1'b0, NONE_WORD},
    '{ROW_CFG,   IDX_H, 7'd127, 1'b0, 1'b0, NONE_WORD},
    '{ROW_QUERY, 7'd0, 7'd1, 1'b0, 1'b0, NONE_WORD},
    '{ROW_CFG,   IDX_W, 7'd2, 1'b0, 1'b0, NONE_WORD},
    '{ROW_CFG,   IDX_H, 7'd2, 1'b0, 1'b0, NONE_WORD},
    '{ROW_QUERY, 7'd1, 7'd1, 1'b0, 1'b1, AT_0_1}
  };

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_GRID_WIDTH;
  logic [DIM_W-1:0]       cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   action    = ACT_WRITE;
  logic [COORD_W-1:0]     cell_x    = '0;
  logic [COORD_W-1:0]     cell_y    = '0;
  logic                   passable  = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COORD_W-1:0]     neighbour_x;
  logic [COORD_W-1:0]     neighbour_y;
  logic                   found;
  logic                   last;

  logic             open_map [CELL_COUNT];
  bit               written  [CELL_COUNT];
  logic [DIM_W-1:0] grid_w = 7'd64;
  logic [DIM_W-1:0] grid_h = 7'd64;
  nbr_word_t        pending_nbrs [$];

  int mismatch_cnt = 0;
  int cycle_cnt    = 0;
  int hold_cnt     = 0;
  int snk_stall    = 0;
  int sent_cnt     = 0;
  bit src_idle_on  = 1'b1;
  bit snk_idle_on  = 1'b1;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;

  grid_neighbour_generator_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int eff_dim(logic [DIM_W-1:0] r, int cap);
    int v;
    v = (r == '0) ? 1 : int'(r);
    if (v > COORD_SPAN) v = COORD_SPAN;
    if (v > cap) v = cap;
    return v;
  endfunction

  function automatic bit is_open(int x, int y);
    return open_map[y * MAX_WIDTH + x] == 1'b1;
  endfunction

  function automatic void add_word(int x, int y, logic f);
    nbr_word_t wd;
    wd.x     = COORD_W'(x);
    wd.y     = COORD_W'(y);
    wd.found = f;
    wd.last  = 1'b0;
    pending_nbrs.insert(pending_nbrs.size(), wd);
  endfunction

  function automatic void list_neighbours(int x, int y);
    int w;
    int h;
    int n0;
    bit r;
    bit l;
    bit u;
    bit d;
    w  = eff_dim(grid_w, MAX_WIDTH);
    h  = eff_dim(grid_h, MAX_HEIGHT);
    n0 = pending_nbrs.size();
    if (x < w && y < h) begin
      r = (x + 1 < w) && is_open(x + 1, y);
      l = (x > 0) && is_open(x - 1, y);
      u = (y > 0) && is_open(x, y - 1);
      d = (y + 1 < h) && is_open(x, y + 1);
      if (r) add_word(x + 1, y, 1'b1);
      if (l) add_word(x - 1, y, 1'b1);
      if (u) add_word(x, y - 1, 1'b1);
      if (d) add_word(x, y + 1, 1'b1);
      if (u && l && is_open(x - 1, y - 1)) add_word(x - 1, y - 1, 1'b1);
      if (u && r && is_open(x + 1, y - 1)) add_word(x + 1, y - 1, 1'b1);
      if (d && l && is_open(x - 1, y + 1)) add_word(x - 1, y + 1, 1'b1);
      if (d && r && is_open(x + 1, y + 1)) add_word(x + 1, y + 1, 1'b1);
    end
    if (pending_nbrs.size() == n0) add_word(0, 0, 1'b0);
    pending_nbrs[pending_nbrs.size() - 1].last = 1'b1;
  endfunction

  function automatic int pick_coord(int span);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return $urandom_range(0, (span < 9) ? span : 9);
    if (roll < 17) return $urandom_range(58, 63);
    return $urandom_range(0, 63);
  endfunction

  function automatic void note_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, what);
  endfunction

  task automatic src_gap();
    int n;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(logic act, int x, int y, logic pass, bit typed,
                           nbr_word_t want);
    src_gap();
    @(negedge clk);
    in_valid <= 1'b1;
    action   <= act;
    cell_x   <= COORD_W'(x);
    cell_y   <= COORD_W'(y);
    passable <= pass;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (act == ACT_WRITE) begin
      open_map[y * MAX_WIDTH + x] = pass;
      written[y * MAX_WIDTH + x]  = 1'b1;
    end else if (typed) begin
      pending_nbrs.insert(pending_nbrs.size(), want);
    end else begin
      list_neighbours(x, y);
    end
  endtask

  // keep every cell a query may touch written, wrap-around included
  task automatic fill_around(int x, int y, bit rand_fill);
    int cx;
    int cy;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        cx = (x + dx + MAX_WIDTH) % MAX_WIDTH;
        cy = (y + dy + MAX_HEIGHT) % MAX_HEIGHT;
        if (!written[cy * MAX_WIDTH + cx])
          send_item(ACT_WRITE, cx, cy, rand_fill && ($urandom_range(0, 9) < 7),
                    1'b0, NONE_WORD);
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_nbrs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_GRID_WIDTH) grid_w = val;
    else grid_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      hold_cnt       = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (snk_stall > 0) begin
      snk_stall--;
      out_ready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
      snk_stall = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    nbr_word_t got;
    nbr_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{neighbour_x, neighbour_y, found, last};
      if (pending_nbrs.size() == 0) begin
        note_mismatch($sformatf("unexpected word x=%0d y=%0d found=%0b last=%0b",
                                got.x, got.y, got.found, got.last));
      end else begin
        want = pending_nbrs[0];
        pending_nbrs.delete(0);
        if (got.x !== want.x || got.y !== want.y || got.found !== want.found ||
            got.last !== want.last)
          note_mismatch($sformatf(
            "word mismatch: exp x=%0d y=%0d found=%0b last=%0b, got x=%0d y=%0d found=%0b last=%0b",
            want.x, want.y, want.found, want.last,
            got.x, got.y, got.found, got.last));
      end
    end
  end

  initial begin
    dir_row_t r;
    int       w0;
    int       h0;
    int       x;
    int       y;
    int       phase_end;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      r = DIR_ROWS[i];
      case (r.kind)
        ROW_WRITE: begin
          send_item(ACT_WRITE, r.a, r.b, r.pass, 1'b0, NONE_WORD);
        end
        ROW_QUERY: begin
          fill_around(r.a, r.b, 1'b0);
          send_item(ACT_QUERY, r.a, r.b, 1'b0, r.typed, r.want);
        end
        default: begin
          write_reg(cfg_reg_t'(r.a[CFG_INDEX_W-1:0]), r.b);
        end
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          w0 = 64;
          h0 = 64;
        end
        1: begin
          w0 = $urandom_range(2, 9);
          h0 = $urandom_range(2, 9);
        end
        2: begin
          w0 = 1;
          h0 = $urandom_range(1, 9);
        end
        3: begin
          w0 = 127;
          h0 = 0;
        end
        4: begin
          w0 = $urandom_range(65, 127);
          h0 = $urandom_range(2, 9);
        end
        5: begin
          w0 = $urandom_range(2, 9);
          h0 = $urandom_range(2, 9);
        end
        default: begin
          w0 = 64;
          h0 = 64;
        end
      endcase
      src_idle_on = !(ph == 1 || ph == 3 || ph == PHASES - 1);
      snk_idle_on = !(ph == 4 || ph == PHASES - 1);
      write_reg(CFG_GRID_WIDTH, DIM_W'(w0));
      write_reg(CFG_GRID_HEIGHT, DIM_W'(h0));
      // receiver stalls while queries keep coming
      if (ph == 1) long_hold_req = 1'b1;
      phase_end = sent_cnt + PHASE_ITEMS;
      while (sent_cnt < phase_end) begin
        x = pick_coord(eff_dim(grid_w, MAX_WIDTH));
        y = pick_coord(eff_dim(grid_h, MAX_HEIGHT));
        if ($urandom_range(0, 99) < 55) begin
          fill_around(x, y, 1'b1);
          send_item(ACT_QUERY, x, y, $urandom_range(0, 1), 1'b0, NONE_WORD);
        end else begin
          send_item(ACT_WRITE, x, y, $urandom_range(0, 9) < 7, 1'b0, NONE_WORD);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_nbrs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
